@@ src/khash_pkg.sv @@
// Shared types and constants for the key bucket hash block.
`default_nettype none

package khash_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 8;
  localparam int unsigned ModW    = 17;
  localparam int unsigned HashW   = 32;
  localparam int unsigned BucketW = 16;
  localparam int unsigned CfgW    = 17;

  // Configuration register indexes.
  localparam logic REG_KEY_LENGTH   = 1'b0;
  localparam logic REG_BUCKET_COUNT = 1'b1;

  typedef enum logic [1:0] {
    OP_ADD_BYTE,
    OP_ADD_SCALED,
    OP_MUL
  } op_e;

  typedef struct packed {
    op_e              op;
    logic             last;
    logic [ByteW-1:0] key_byte;
    logic [LenW-1:0]  position;
    logic [LenW-1:0]  key_length;
    logic [ModW-1:0]  modulus;
  } entry_t;

  typedef struct packed {
    logic             valid;
    logic [HashW-1:0] dividend;
    logic [ModW-1:0]  modulus;
  } div_req_t;

endpackage

`default_nettype wire

@@ src/khash_front.sv @@
// Front end: accepts key bytes, tracks the byte position and classifies each byte.
`default_nettype none

module khash_front #(
  parameter int unsigned MaxBuckets = 65536
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             in_valid_i,
  output logic                            in_stall_o,
  input  wire [khash_pkg::ByteW-1:0]      key_byte_i,
  input  wire [khash_pkg::LenW-1:0]       key_length_i,
  input  wire [khash_pkg::CfgW-1:0]       bucket_count_i,
  output logic                            push_o,
  output khash_pkg::entry_t               entry_o,
  input  wire                             full_i
);
  import khash_pkg::*;

  localparam logic [ModW-1:0] MaxCap = ModW'(MaxBuckets);

  logic [LenW-1:0] pos_q, pos_d;
  logic [LenW:0]   pos_next;
  logic            last;
  logic [ModW-1:0] modulus;

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;
  assign pos_next   = {1'b0, pos_q} + {{LenW{1'b0}}, 1'b1};
  assign last       = !(pos_next < {1'b0, key_length_i});

  // The modulus saturates at the parameter limit and a zero count acts as one.
  always_comb begin
    modulus = bucket_count_i;
    if (32'(bucket_count_i) > 32'(MaxBuckets)) begin
      modulus = MaxCap;
    end
    if (modulus == '0) begin
      modulus = ModW'(1);
    end
  end

  always_comb begin
    entry_o.last       = last;
    entry_o.key_byte   = key_byte_i;
    entry_o.position   = pos_q;
    entry_o.key_length = key_length_i;
    entry_o.modulus    = modulus;
    if (pos_q == '0) begin
      entry_o.op = OP_ADD_BYTE;
    end else if (pos_q == LenW'(1)) begin
      entry_o.op = OP_ADD_SCALED;
    end else begin
      entry_o.op = OP_MUL;
    end
  end

  always_comb begin
    pos_d = pos_q;
    if (push_o) begin
      pos_d = last ? '0 : pos_next[LenW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

`default_nettype wire

@@ src/khash_queue.sv @@
// Short request queue between the front end and the hash back end.
`default_nettype none

module khash_queue #(
  parameter int unsigned Depth = 2
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                push_i,
  input  khash_pkg::entry_t  entry_i,
  output logic               full_o,
  output logic               valid_o,
  input  wire                pop_i,
  output khash_pkg::entry_t  entry_o
);
  import khash_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == FullCnt);
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("queue popped while empty");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue pushed while full");
  a_count_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> count_q == $past(count_q) + CntW'(1))
    else $error("queue count did not follow a push");
`endif

endmodule

`default_nettype wire

@@ src/khash_back.sv @@
// Back end: applies each classified byte to the running hash and forms the final product.
`default_nettype none

module khash_back (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                q_valid_i,
  input  khash_pkg::entry_t  entry_i,
  output logic               q_pop_o,
  output khash_pkg::div_req_t div_req_o,
  input  wire                div_ready_i
);
  import khash_pkg::*;

  typedef enum logic [1:0] {
    B_IDLE,
    B_UPD,
    B_FIN
  } state_e;

  state_e           state_q;
  logic [HashW-1:0] hash_q;
  logic [16:0]      factor_q;
  logic [15:0]      addend_q;
  logic             add_q;
  logic             last_q;
  logic [LenW-1:0]  klen_q;
  logic [ModW-1:0]  mod_q;

  logic [15:0]      byte_by_pos;
  logic [15:0]      byte_by_len;
  logic [16:0]      factor_d;
  logic [48:0]      upd_prod;
  logic [39:0]      fin_prod;

  assign byte_by_pos = entry_i.key_byte * entry_i.position;
  assign byte_by_len = entry_i.key_byte * entry_i.key_length;
  assign factor_d    = {1'b0, byte_by_pos} + {9'b0, entry_i.key_length}
                     + {9'b0, entry_i.position};
  assign upd_prod    = hash_q * factor_q;
  assign fin_prod    = hash_q * klen_q;

  assign q_pop_o            = (state_q == B_IDLE) && q_valid_i;
  assign div_req_o.valid    = (state_q == B_FIN);
  assign div_req_o.dividend = fin_prod[HashW-1:0];
  assign div_req_o.modulus  = mod_q;

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      factor_q <= factor_d;
      addend_q <= (entry_i.op == OP_ADD_BYTE) ? {8'b0, entry_i.key_byte} : byte_by_len;
      add_q    <= (entry_i.op != OP_MUL);
      last_q   <= entry_i.last;
      klen_q   <= entry_i.key_length;
      mod_q    <= entry_i.modulus;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      hash_q  <= '0;
    end else begin
      unique case (state_q)
        B_IDLE: begin
          if (q_valid_i) begin
            state_q <= B_UPD;
          end
        end
        B_UPD: begin
          hash_q  <= add_q ? hash_q + {16'b0, addend_q} : upd_prod[HashW-1:0];
          state_q <= last_q ? B_FIN : B_IDLE;
        end
        B_FIN: begin
          // The product is captured by the modulo unit; the next key starts from zero.
          if (div_ready_i) begin
            hash_q  <= '0;
            state_q <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_fin_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_req_o.valid && !div_ready_i) |=> div_req_o.valid && $stable(div_req_o.dividend))
    else $error("final product changed while waiting for the modulo unit");
  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> state_q == B_UPD) else $error("pop did not start an update");
  a_hash_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_req_o.valid && div_ready_i) |=> hash_q == '0)
    else $error("running hash not cleared after a key");
`endif

endmodule

`default_nettype wire

@@ src/khash_mod.sv @@
// Bit-serial remainder unit with the result output register.
`default_nettype none

module khash_mod (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  khash_pkg::div_req_t          div_req_i,
  output logic                         div_ready_o,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic [khash_pkg::BucketW-1:0] bucket_index_o
);
  import khash_pkg::*;

  localparam int unsigned CntW = $clog2(HashW);
  localparam logic [CntW-1:0] LastCnt = CntW'(HashW - 1);

  logic                run_q;
  logic [CntW-1:0]     cnt_q;
  logic [HashW-1:0]    dvd_q;
  logic [ModW-1:0]     rem_q;
  logic [ModW-1:0]     mod_q;
  logic                out_valid_q;
  logic [BucketW-1:0]  out_data_q;

  logic [ModW:0]       shifted;
  logic                ge;
  logic [ModW-1:0]     rem_next;
  logic                out_free;
  logic                step;
  logic                finish;

  assign shifted  = {rem_q, dvd_q[HashW-1]};
  assign ge       = (shifted >= {1'b0, mod_q});
  assign rem_next = ge ? ModW'(shifted - {1'b0, mod_q}) : shifted[ModW-1:0];
  assign out_free = !out_valid_q || !out_stall_i;
  // The last step waits until the output register can take the result.
  assign step     = run_q && ((cnt_q != LastCnt) || out_free);
  assign finish   = step && (cnt_q == LastCnt);

  assign div_ready_o    = !run_q;
  assign out_valid_o    = out_valid_q;
  assign bucket_index_o = out_data_q;

  always_ff @(posedge clk_i) begin
    if (div_req_i.valid && !run_q) begin
      dvd_q <= div_req_i.dividend;
      mod_q <= div_req_i.modulus;
      rem_q <= '0;
    end else if (step) begin
      dvd_q <= {dvd_q[HashW-2:0], 1'b0};
      rem_q <= rem_next;
    end
    if (finish) begin
      out_data_q <= rem_next[BucketW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (div_req_i.valid && !run_q) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (step) begin
        cnt_q <= cnt_q + CntW'(1);
        if (finish) begin
          run_q <= 1'b0;
        end
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_rem_below_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_q && cnt_q != '0) |-> rem_q < mod_q)
    else $error("partial remainder not below the modulus");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |-> out_free) else $error("result overwrote a pending output");
  a_finish_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> !run_q && out_valid_q) else $error("modulo did not complete");
`endif

endmodule

`default_nettype wire

@@ src/key_bucket_hash_core.sv @@
// Top level of the key bucket hash block: configuration registers and unit wiring.
//
// Usage: each request on the input channel carries one key byte (key_byte_i);
// bytes of a key arrive in order. After the key_length-th byte the block
// delivers one request on the output channel with the bucket index of that key.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i, index 0
// key length, index 1 bucket count; it takes effect from the next byte.
// The hash back end prepares the operands of each byte, then applies an add or
// a 32x17 multiply to the running hash; after the last byte of a key it forms
// the final product with the key length. The bucket index comes from a
// bit-serial remainder unit that takes a new key only after the previous one
// is done; it runs while the next key's bytes are hashed.
// A two-entry queue decouples the byte front end from the hash back end;
// in_stall_o rises only when that queue is full.
// When the receiver stalls, the result is held in the output register; the
// remainder unit then holds its final step and the back end waits in turn.
// Reset sets key length 32, bucket count 1024, and clears hash and position.
`default_nettype none

module key_bucket_hash_core #(
  parameter int unsigned MAX_BUCKETS = 65536
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             cfg_we_i,
  input  wire                             cfg_idx_i,
  input  wire [khash_pkg::CfgW-1:0]       cfg_data_i,
  input  wire                             in_valid_i,
  output logic                            in_stall_o,
  input  wire [khash_pkg::ByteW-1:0]      key_byte_i,
  output logic                            out_valid_o,
  input  wire                             out_stall_i,
  output logic [khash_pkg::BucketW-1:0]   bucket_index_o
);
  import khash_pkg::*;

  logic [LenW-1:0] key_length_q;
  logic [CfgW-1:0] bucket_count_q;

  logic     push;
  logic     q_full;
  logic     q_valid;
  logic     q_pop;
  entry_t   front_entry;
  entry_t   head_entry;
  div_req_t div_req;
  logic     div_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_length_q   <= LenW'(32);
      bucket_count_q <= CfgW'(1024);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_KEY_LENGTH:   key_length_q   <= cfg_data_i[LenW-1:0];
        REG_BUCKET_COUNT: bucket_count_q <= cfg_data_i;
      endcase
    end
  end

  khash_front #(
    .MaxBuckets(MAX_BUCKETS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .key_byte_i    (key_byte_i),
    .key_length_i  (key_length_q),
    .bucket_count_i(bucket_count_q),
    .push_o        (push),
    .entry_o       (front_entry),
    .full_i        (q_full)
  );

  khash_queue #(
    .Depth(2)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(front_entry),
    .full_o (q_full),
    .valid_o(q_valid),
    .pop_i  (q_pop),
    .entry_o(head_entry)
  );

  khash_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .entry_i    (head_entry),
    .q_pop_o    (q_pop),
    .div_req_o  (div_req),
    .div_ready_i(div_ready)
  );

  khash_mod u_mod (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .div_req_i     (div_req),
    .div_ready_o   (div_ready),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .bucket_index_o(bucket_index_o)
  );

endmodule

`default_nettype wire
